/* design/grsm_pkg.sv */
// Shared constants, types and modular arithmetic helpers for the grid range-sum block.
`default_nettype none

package grsm_pkg;

    localparam int GRID_MAX  = 64;
    localparam int IDX_W     = $clog2(GRID_MAX);
    localparam int CNT_W     = $clog2(GRID_MAX + 1);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int VAL_W     = 30;
    localparam int COORD_W   = 7;
    localparam int GSIZE_W   = 7;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = (COORD_W > CNT_W) ? COORD_W : CNT_W;
    localparam int MUL_CNT_W = $clog2(VAL_W);

    localparam logic [VAL_W-1:0]   MODULUS       = 30'd1000000007;
    localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 7'd64;

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_MUL   = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL      = 2'd1;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] prod;
    } t_mul_rsp;

    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] d;
        d = a - b;
        if (a < b) begin
            d = d + MODULUS;
        end
        return d;
    endfunction

    function automatic logic [VAL_W-1:0] mod_reduce(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] r;
        r = x;
        if (x >= MODULUS) begin
            r = x - MODULUS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/grsm_ram.sv */
// Simple dual-port synchronous RAM, registered read, write-to-read bypass.
`default_nettype none

module grsm_ram #(
    parameter int WIDTH  = 30,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/grsm_modmul.sv */
// Iterative modular multiplier: one double or one conditional add per cycle.
`default_nettype none

module grsm_modmul
    import grsm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_phase;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_acc;
    logic [VAL_W-1:0]     r_a;
    logic [VAL_W-1:0]     r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= MUL_CNT_W'(VAL_W - 1);
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - MUL_CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_acc <= mod_add(r_acc, r_acc);
            end else begin
                if (r_b[VAL_W-1]) begin
                    r_acc <= mod_add(r_acc, r_a);
                end
                r_b <= r_b << 1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

`default_nettype wire

/* design/grid_range_sum_mod_point_multiply.sv */
// Top level: grid range-sum block with point multiply, controller and prefix rebuild.
//
//   channel   handshake                     payload
//   input     start / busy                  i_operation, i_first_row, i_first_col,
//                                           i_last_row, i_last_col, i_factor
//   result    o_valid (one-cycle strobe)    o_rect_sum
//   config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// Query: four prefix RAM reads, one per cycle in ST_QRY, then ST_QLAST and the registered result strobe;
//   an empty rectangle answers through the result register alone, with no RAM reads.
// Multiply: cell read, modular multiplier, then prefix rebuild (ST_SWEEP, ST_DRAIN); restart: refill and rebuild.
//   The rebuild writes one prefix entry per cycle through the prefix RAM write port.
// After reset a clearing pass (ST_CLEAR) over all GRID_MAX^2 entries zeroes both RAMs with busy high.
// Results cannot be stalled; config writes are always taken.
`default_nettype none

module grid_range_sum_mod_point_multiply
    import grsm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [COORD_W-1:0]   i_first_row,
    input  wire logic [COORD_W-1:0]   i_first_col,
    input  wire logic [COORD_W-1:0]   i_last_row,
    input  wire logic [COORD_W-1:0]   i_last_col,
    input  wire logic [VAL_W-1:0]     i_factor,
    output logic                      o_valid,
    output logic      [VAL_W-1:0]     o_rect_sum,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_data
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STATE_W-1:0] ST_MRD   = 4'd1;
    localparam logic [STATE_W-1:0] ST_MWAIT = 4'd2;
    localparam logic [STATE_W-1:0] ST_MMUL  = 4'd3;
    localparam logic [STATE_W-1:0] ST_SWEEP = 4'd4;
    localparam logic [STATE_W-1:0] ST_DRAIN = 4'd5;
    localparam logic [STATE_W-1:0] ST_QRY   = 4'd6;
    localparam logic [STATE_W-1:0] ST_QLAST = 4'd7;
    localparam logic [STATE_W-1:0] ST_CLEAR = 4'd8;

    localparam logic [1:0] QOP_NONE = 2'd0;
    localparam logic [1:0] QOP_ADD  = 2'd1;
    localparam logic [1:0] QOP_SUB  = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_MAX - 1);

    function automatic logic [CNT_W-1:0] active_size(input logic [GSIZE_W-1:0] g);
        logic [CMP_W-1:0] ge;
        logic [CMP_W-1:0] cl;
        ge = CMP_W'(g);
        if (ge == '0) begin
            cl = CMP_W'(1);
        end else if (ge > CMP_W'(GRID_MAX)) begin
            cl = CMP_W'(GRID_MAX);
        end else begin
            cl = ge;
        end
        return cl[CNT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [COORD_W-1:0] v,
                                                   input logic [CNT_W-1:0]   n);
        logic [CMP_W-1:0] ve;
        logic [CMP_W-1:0] ne;
        logic [CMP_W-1:0] cl;
        ve = CMP_W'(v);
        ne = CMP_W'(n);
        if (ve == '0) begin
            cl = CMP_W'(1);
        end else if (ve > ne) begin
            cl = ne;
        end else begin
            cl = ve;
        end
        cl = cl - CMP_W'(1);
        return cl[IDX_W-1:0];
    endfunction

    function automatic logic in_grid(input logic [COORD_W-1:0] v,
                                     input logic [CNT_W-1:0]   n);
        return (CMP_W'(v) != '0) && (CMP_W'(v) <= CMP_W'(n));
    endfunction

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [GSIZE_W-1:0] r_grid_size;
    logic [VAL_W-1:0]   r_fill;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic               r_p1_v;
    logic               r_p2_v;
    logic               r_valid;
    logic [1:0]         r_qop;

    logic               r_restart;
    logic [VAL_W-1:0]   r_fv;
    logic [CNT_W-1:0]   r_n;
    logic [VAL_W-1:0]   r_factor;
    logic [ADDR_W-1:0]  r_tgt;
    logic [IDX_W-1:0]   r_r1;
    logic [IDX_W-1:0]   r_c1;
    logic [IDX_W-1:0]   r_r2;
    logic [IDX_W-1:0]   r_c2;
    logic [1:0]         r_step;
    logic [VAL_W-1:0]   r_acc;
    logic [VAL_W-1:0]   r_sum;
    logic [ADDR_W-1:0]  r_p1_addr;
    logic               r_p1_col0;
    logic               r_p1_row0;
    logic [VAL_W-1:0]   r_p1_cell;
    logic [VAL_W-1:0]   r_rowsum;
    logic [VAL_W-1:0]   r_up;
    logic [ADDR_W-1:0]  r_p2_addr;

    logic [CNT_W-1:0]   act_n;
    logic               accept;
    logic [IDX_W-1:0]   q_r1;
    logic [IDX_W-1:0]   q_c1;
    logic [IDX_W-1:0]   q_r2;
    logic [IDX_W-1:0]   q_c2;
    logic               q_empty;
    logic               mul_in;
    logic               sweep_last;
    logic [ADDR_W-1:0]  sweep_addr;
    logic [VAL_W-1:0]   sweep_fill;
    logic [ADDR_W-1:0]  q_addr;
    logic [1:0]         q_op;
    logic [VAL_W-1:0]   acc_n;
    logic [VAL_W-1:0]   p1_cell;
    logic [VAL_W-1:0]   rowsum_n;

    logic               cell_we;
    logic [ADDR_W-1:0]  cell_waddr;
    logic [VAL_W-1:0]   cell_wdata;
    logic [ADDR_W-1:0]  cell_raddr;
    logic [VAL_W-1:0]   cell_rdata;
    logic               pref_we;
    logic [ADDR_W-1:0]  pref_waddr;
    logic [VAL_W-1:0]   pref_wdata;
    logic [ADDR_W-1:0]  pref_raddr;
    logic [VAL_W-1:0]   pref_rdata;

    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;

    assign act_n   = active_size(r_grid_size);
    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign q_r1    = clamp_idx(i_first_row, act_n);
    assign q_c1    = clamp_idx(i_first_col, act_n);
    assign q_r2    = clamp_idx(i_last_row, act_n);
    assign q_c2    = clamp_idx(i_last_col, act_n);
    assign q_empty = (q_r1 > q_r2) || (q_c1 > q_c2);
    assign mul_in  = in_grid(i_first_row, act_n) && in_grid(i_first_col, act_n);

    assign sweep_last = (r_row == LAST_IDX) && (r_col == LAST_IDX);
    assign sweep_addr = {r_row, r_col};
    assign sweep_fill = ((CNT_W'(r_row) < r_n) && (CNT_W'(r_col) < r_n)) ? r_fv : '0;

    always_comb begin
        case (r_step)
            2'd0: begin
                q_addr = {r_r2, r_c2};
                q_op   = QOP_ADD;
            end
            2'd1: begin
                q_addr = {r_r1 - IDX_W'(1), r_c2};
                q_op   = (r_r1 != '0) ? QOP_SUB : QOP_NONE;
            end
            2'd2: begin
                q_addr = {r_r2, r_c1 - IDX_W'(1)};
                q_op   = (r_c1 != '0) ? QOP_SUB : QOP_NONE;
            end
            default: begin
                q_addr = {r_r1 - IDX_W'(1), r_c1 - IDX_W'(1)};
                q_op   = ((r_r1 != '0) && (r_c1 != '0)) ? QOP_ADD : QOP_NONE;
            end
        endcase
    end

    always_comb begin
        case (r_qop)
            QOP_ADD: acc_n = mod_add(r_acc, pref_rdata);
            QOP_SUB: acc_n = mod_sub(r_acc, pref_rdata);
            default: acc_n = r_acc;
        endcase
    end

    assign p1_cell  = r_restart ? r_p1_cell : cell_rdata;
    assign rowsum_n = mod_add(r_p1_col0 ? '0 : r_rowsum, p1_cell);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_QUERY: n_state = q_empty ? ST_IDLE : ST_QRY;
                        OP_MUL:   n_state = mul_in ? ST_MRD : ST_IDLE;
                        OP_FILL:  n_state = ST_SWEEP;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MRD:   n_state = ST_MWAIT;
            ST_MWAIT: n_state = ST_MMUL;
            ST_MMUL: begin
                if (mul_rsp.done) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_v) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRY: begin
                if (r_step == 2'd3) begin
                    n_state = ST_QLAST;
                end
            end
            ST_QLAST: n_state = ST_IDLE;
            ST_CLEAR: begin
                if (sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_grid_size <= GRID_SIZE_RST;
            r_fill      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_valid     <= 1'b0;
            r_qop       <= QOP_NONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GRID_SIZE: r_grid_size <= i_cfg_data[GSIZE_W-1:0];
                    REG_FILL:      r_fill      <= i_cfg_data;
                    default:       ;
                endcase
            end
            if (accept) begin
                r_row <= '0;
                r_col <= '0;
            end else if ((r_state == ST_SWEEP) || (r_state == ST_CLEAR)) begin
                if (r_col == LAST_IDX) begin
                    r_col <= '0;
                    r_row <= r_row + IDX_W'(1);
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end
            r_p1_v  <= (r_state == ST_SWEEP);
            r_p2_v  <= r_p1_v;
            r_valid <= (r_state == ST_QLAST) ||
                       (accept && (i_operation == OP_QUERY) && q_empty);
            r_qop   <= (r_state == ST_QRY) ? q_op : QOP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_restart <= (i_operation == OP_FILL);
            r_fv      <= mod_reduce(r_fill);
            r_n       <= act_n;
            r_factor  <= mod_reduce(i_factor);
            r_tgt     <= {q_r1, q_c1};
            r_r1      <= q_r1;
            r_c1      <= q_c1;
            r_r2      <= q_r2;
            r_c2      <= q_c2;
            r_step    <= '0;
            r_acc     <= '0;
        end else begin
            r_acc <= acc_n;
            if (r_state == ST_QRY) begin
                r_step <= r_step + 2'd1;
            end
        end
        if (r_state == ST_QLAST) begin
            r_sum <= acc_n;
        end else if (accept && (i_operation == OP_QUERY) && q_empty) begin
            r_sum <= '0;
        end
        r_p1_addr <= sweep_addr;
        r_p1_col0 <= (r_col == '0);
        r_p1_row0 <= (r_row == '0);
        r_p1_cell <= sweep_fill;
        if (r_p1_v) begin
            r_rowsum  <= rowsum_n;
            r_up      <= r_p1_row0 ? '0 : pref_rdata;
            r_p2_addr <= r_p1_addr;
        end
    end

    assign mul_req.start = (r_state == ST_MWAIT);
    assign mul_req.a     = cell_rdata;
    assign mul_req.b     = r_factor;

    grsm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = sweep_addr;
        cell_wdata = '0;
        case (r_state)
            ST_MMUL: begin
                cell_we    = mul_rsp.done;
                cell_waddr = r_tgt;
                cell_wdata = mul_rsp.prod;
            end
            ST_SWEEP: begin
                cell_we    = r_restart;
                cell_wdata = sweep_fill;
            end
            ST_CLEAR: begin
                cell_we    = 1'b1;
            end
            default: ;
        endcase
    end

    assign cell_raddr = (r_state == ST_MRD) ? r_tgt : sweep_addr;

    grsm_ram #(
        .WIDTH  (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    assign pref_we    = r_p2_v || (r_state == ST_CLEAR);
    assign pref_waddr = r_p2_v ? r_p2_addr : sweep_addr;
    assign pref_wdata = r_p2_v ? mod_add(r_rowsum, r_up) : '0;
    assign pref_raddr = (r_state == ST_QRY) ? q_addr : {r_row - IDX_W'(1), r_col};

    grsm_ram #(
        .WIDTH  (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_pref_ram (
        .i_clk   (i_clk),
        .i_we    (pref_we),
        .i_waddr (pref_waddr),
        .i_wdata (pref_wdata),
        .i_raddr (pref_raddr),
        .o_rdata (pref_rdata)
    );

    assign o_valid     = r_valid;
    assign o_rect_sum  = r_sum;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (!r_p1_v && !r_p2_v))
        else $error("rebuild writes pending while idle");

    a_pref_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pref_we |-> ((r_state == ST_SWEEP) || (r_state == ST_DRAIN) ||
                     (r_state == ST_CLEAR)))
        else $error("prefix RAM written outside a sweep");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == ST_MMUL))
        else $error("multiplier finished outside its wait state");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (($past(r_state) == ST_QLAST) ||
                     $past(start && !busy && (i_operation == OP_QUERY))))
        else $error("result strobe without a query");
`endif

endmodule

`default_nettype wire

/* bench/grid_range_sum_mod_point_multiply_tb.sv */
// Testbench for the grid range-sum block: directed table, then random traffic against a grid predictor.
`timescale 1ns / 100ps

module grid_range_sum_mod_point_multiply_tb;
    import grsm_pkg::*;

    localparam logic [OP_W-1:0]      OP_NONE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [VAL_W-1:0]     VAL_ALL     = '1;
    localparam longint unsigned      MOD_P       = MODULUS;
    localparam int SETTLE_CYCLES  = GRID_MAX * GRID_MAX + 2 * VAL_W + 32;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int NUM_STEPS      = 33;
    localparam int NUM_PHASES     = 4;
    localparam int PHASE_ITEMS    = 29;

    typedef struct packed {
        logic               is_cfg;
        logic [1:0]         code;
        logic [COORD_W-1:0] r_a;
        logic [COORD_W-1:0] c_a;
        logic [COORD_W-1:0] r_b;
        logic [COORD_W-1:0] c_b;
        logic [VAL_W-1:0]   data;
        logic               known;
        logic [VAL_W-1:0]   sum;
    } t_step;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_operation = OP_QUERY;
    logic [COORD_W-1:0]   i_first_row = '0;
    logic [COORD_W-1:0]   i_first_col = '0;
    logic [COORD_W-1:0]   i_last_row  = '0;
    logic [COORD_W-1:0]   i_last_col  = '0;
    logic [VAL_W-1:0]     i_factor    = '0;
    logic                 o_valid;
    logic [VAL_W-1:0]     o_rect_sum;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_GRID_SIZE;
    logic [VAL_W-1:0]     i_cfg_data  = '0;

    bit   [VAL_W-1:0]     grid_cells [GRID_MAX][GRID_MAX];
    bit   [GSIZE_W-1:0]   grid_size_reg = GRID_SIZE_RST;
    bit   [VAL_W-1:0]     fill_reg      = '0;
    logic [VAL_W-1:0]     pending_sums [$];
    logic [VAL_W-1:0]     expected_sum;
    int                   mismatches  = 0;
    int                   idle_cycles = 0;

    t_step directed_steps [NUM_STEPS] = '{
        '{1'b0, OP_QUERY,      7'd1,   7'd1,  7'd64,  7'd64,  30'd0,          1'b1, 30'd0},
        '{1'b0, OP_MUL,        7'd1,   7'd1,  7'd0,   7'd0,   30'd5,          1'b0, 30'd0},
        '{1'b1, REG_FILL,      7'd0,   7'd0,  7'd0,   7'd0,   MODULUS + 30'd1, 1'b0, 30'd0},
        '{1'b1, REG_SPARE_A,   7'd0,   7'd0,  7'd0,   7'd0,   VAL_ALL,        1'b0, 30'd0},
        '{1'b1, REG_SPARE_B,   7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_FILL,       7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd1,   7'd1,  7'd64,  7'd64,  30'd0,          1'b1, 30'd4096},
        '{1'b0, OP_QUERY,      7'd0,   7'd0,  7'd127, 7'd127, 30'd0,          1'b1, 30'd4096},
        '{1'b0, OP_QUERY,      7'd5,   7'd5,  7'd4,   7'd4,   30'd0,          1'b1, 30'd0},
        '{1'b0, OP_MUL,        7'd64,  7'd64, 7'd0,   7'd0,   MODULUS - 30'd1, 1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd64,  7'd64, 7'd64,  7'd64,  30'd0,     1'b1, MODULUS - 30'd1},
        '{1'b0, OP_MUL,        7'd0,   7'd3,  7'd0,   7'd0,   30'd7,          1'b0, 30'd0},
        '{1'b0, OP_MUL,        7'd65,  7'd1,  7'd0,   7'd0,   30'd7,          1'b0, 30'd0},
        '{1'b0, OP_MUL,        7'd2,   7'd3,  7'd0,   7'd0,   VAL_ALL,        1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd2,   7'd3,  7'd2,   7'd3,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_NONE,       7'd1,   7'd1,  7'd64,  7'd64,  VAL_ALL,        1'b0, 30'd0},
        '{1'b1, REG_GRID_SIZE, 7'd0,   7'd0,  7'd0,   7'd0,   30'd1,          1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd1,   7'd1,  7'd64,  7'd64,  30'd0,          1'b1, 30'd1},
        '{1'b0, OP_FILL,       7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_MUL,        7'd2,   7'd1,  7'd0,   7'd0,   30'd9,          1'b0, 30'd0},
        '{1'b0, OP_MUL,        7'd1,   7'd1,  7'd0,   7'd0,   30'd3,          1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd127, 7'd0,  7'd3,   7'd64,  30'd0,          1'b0, 30'd0},
        '{1'b1, REG_GRID_SIZE, 7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b1, REG_FILL,      7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_FILL,       7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd1,   7'd1,  7'd1,   7'd1,   30'd0,          1'b1, 30'd0},
        '{1'b1, REG_GRID_SIZE, 7'd0,   7'd0,  7'd0,   7'd0,   30'd127,        1'b0, 30'd0},
        '{1'b1, REG_FILL,      7'd0,   7'd0,  7'd0,   7'd0,   MODULUS - 30'd1, 1'b0, 30'd0},
        '{1'b0, OP_FILL,       7'd0,   7'd0,  7'd0,   7'd0,   30'd0,          1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd1,   7'd1,  7'd1,   7'd1,   30'd0,     1'b1, MODULUS - 30'd1},
        '{1'b0, OP_QUERY,      7'd3,   7'd1,  7'd64,  7'd64,  30'd0,          1'b0, 30'd0},
        '{1'b0, OP_QUERY,      7'd64,  7'd1,  7'd63,  7'd64,  30'd0,          1'b1, 30'd0},
        '{1'b0, OP_QUERY,      7'd1,   7'd64, 7'd64,  7'd63,  30'd0,          1'b1, 30'd0}
    };

    grid_range_sum_mod_point_multiply i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_first_row (i_first_row),
        .i_first_col (i_first_col),
        .i_last_row  (i_last_row),
        .i_last_col  (i_last_col),
        .i_factor    (i_factor),
        .o_valid     (o_valid),
        .o_rect_sum  (o_rect_sum),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int active_span();
        int n;
        n = int'(grid_size_reg);
        if (n < 1) n = 1;
        if (n > GRID_MAX) n = GRID_MAX;
        return n;
    endfunction

    // zero-based index after limiting to 1..n
    function automatic int clamp_coord(input logic [COORD_W-1:0] v, input int n);
        if (v < 1) return 0;
        if (v > n) return n - 1;
        return int'(v) - 1;
    endfunction

    function automatic bit grid_step(input logic [OP_W-1:0] op,
                                     input logic [COORD_W-1:0] r_a, c_a, r_b, c_b,
                                     input logic [VAL_W-1:0] factor,
                                     output logic [VAL_W-1:0] sum);
        int n, top, left, bottom, right;
        longint unsigned acc, f;
        n = active_span();
        sum = '0;
        acc = 0;
        case (op)
            OP_QUERY: begin
                top    = clamp_coord(r_a, n);
                left   = clamp_coord(c_a, n);
                bottom = clamp_coord(r_b, n);
                right  = clamp_coord(c_b, n);
                for (int r = top; r <= bottom; r++)
                    for (int c = left; c <= right; c++)
                        acc = (acc + grid_cells[r][c]) % MOD_P;
                sum = acc[VAL_W-1:0];
                return 1'b1;
            end
            OP_MUL: begin
                f = factor % MOD_P;
                if (r_a >= 1 && r_a <= n && c_a >= 1 && c_a <= n)
                    grid_cells[r_a-1][c_a-1] =
                        VAL_W'((grid_cells[r_a-1][c_a-1] * f) % MOD_P);
            end
            OP_FILL: begin
                for (int r = 0; r < GRID_MAX; r++)
                    for (int c = 0; c < GRID_MAX; c++)
                        grid_cells[r][c] = (r < n && c < n) ? VAL_W'(fill_reg % MOD_P) : '0;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [COORD_W-1:0] r_a, c_a, r_b, c_b,
                             input logic [VAL_W-1:0] factor,
                             input bit known, input logic [VAL_W-1:0] known_sum);
        logic [VAL_W-1:0] sum;
        start       <= 1'b1;
        i_operation <= op;
        i_first_row <= r_a;
        i_first_col <= c_a;
        i_last_row  <= r_b;
        i_last_col  <= c_b;
        i_factor    <= factor;
        do @(posedge i_clk); while (busy);
        if (grid_step(op, r_a, c_a, r_b, c_b, factor, sum))
            pending_sums.push_back(known ? known_sum : sum);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // wait for every pending sum, then let a rebuild finish
    task automatic drain(input int extra);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_sums.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GRID_SIZE: grid_size_reg = data[GSIZE_W-1:0];
            REG_FILL:      fill_reg = data;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_sums.size() == 0) begin
                $error("rect_sum: unexpected result %0d", o_rect_sum);
                mismatches++;
            end else begin
                expected_sum = pending_sums.pop_front();
                if (o_rect_sum !== expected_sum) begin
                    $error("rect_sum: expected %0d, actual %0d", expected_sum, o_rect_sum);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[grid_range_sum_mod_point_multiply] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n, pick, shape;
        bit cfg_open, calm;
        logic [OP_W-1:0] op;
        logic [COORD_W-1:0] r_a, c_a, r_b, c_b, swap;
        logic [VAL_W-1:0] factor, gsize, fill;
        cfg_open = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                if (!cfg_open) drain(SETTLE_CYCLES);
                write_reg(directed_steps[k].code, directed_steps[k].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_item(directed_steps[k].code, directed_steps[k].r_a, directed_steps[k].c_a,
                          directed_steps[k].r_b, directed_steps[k].c_b, directed_steps[k].data,
                          directed_steps[k].known, directed_steps[k].sum);
                hold_off(pick_gap(1'b0));
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain(SETTLE_CYCLES);
            case (ph)
                0:       gsize = VAL_W'($urandom_range(2, GRID_MAX - 1));
                1:       gsize = VAL_W'(GRID_MAX);
                2:       gsize = VAL_W'($urandom_range(GRID_MAX + 1, 127));
                default: gsize = VAL_W'($urandom_range(1, 8));
            endcase
            if (ph == 1) fill = VAL_W'($urandom_range(MODULUS, VAL_ALL));
            else         fill = VAL_W'($urandom_range(1, MODULUS - 1));
            write_reg(REG_GRID_SIZE, gsize);
            write_reg(REG_FILL, fill);
            i_cfg_valid <= 1'b0;
            calm = (ph == 1);
            send_item(OP_FILL, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), VAL_W'($urandom), 1'b0, '0);
            hold_off(pick_gap(calm));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                n = active_span();
                pick = $urandom_range(0, 99);
                shape = $urandom_range(0, 9);
                r_a = COORD_W'($urandom_range(1, n));
                r_b = COORD_W'($urandom_range(1, n));
                c_a = COORD_W'($urandom_range(1, n));
                c_b = COORD_W'($urandom_range(1, n));
                if (r_a > r_b) begin
                    swap = r_a;
                    r_a = r_b;
                    r_b = swap;
                end
                if (c_a > c_b) begin
                    swap = c_a;
                    c_a = c_b;
                    c_b = swap;
                end
                if (shape == 0) begin
                    r_a = COORD_W'($urandom_range(0, 127));
                    c_a = COORD_W'($urandom_range(0, 127));
                    r_b = COORD_W'($urandom_range(0, 127));
                    c_b = COORD_W'($urandom_range(0, 127));
                end
                if (shape == 1)      factor = VAL_W'($urandom_range(0, VAL_ALL));
                else if (shape == 2) factor = '0;
                else                 factor = VAL_W'($urandom_range(1, MODULUS - 1));
                if (pick < 64)      op = OP_QUERY;
                else if (pick < 90) op = OP_MUL;
                else if (pick < 95) op = OP_FILL;
                else                op = OP_NONE;
                send_item(op, r_a, c_a, r_b, c_b, factor, 1'b0, '0);
                if ($urandom_range(0, 14) == 0) drain(0);
                else                            hold_off(pick_gap(calm));
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("[grid_range_sum_mod_point_multiply] OK");
        end else begin
            $display("[grid_range_sum_mod_point_multiply] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/grsm_pkg.sv
design/grsm_ram.sv
design/grsm_modmul.sv
design/grid_range_sum_mod_point_multiply.sv
bench/grid_range_sum_mod_point_multiply_tb.sv
